// ===== rtl/dhpd_pkg.sv =====
// Package with field widths, gains, fixed-point constants and command codes of the heading drive.
`default_nettype none
package dhpd_pkg;

	localparam int DRIVE_LIMIT_DEF = 255;
	localparam int SUM_WIDTH_DEF   = 24;

	localparam int CMD_W     = 2;
	localparam int HEADING_W = 13;
	localparam int BASE_W    = 9;
	localparam int DUTY_W    = 8;

	localparam int E_W  = 14;
	localparam int DH_W = 14;
	localparam int PE_W = 22;
	localparam int DD_W = 24;
	localparam int B_W  = 19;

	localparam int WRAP_MAG = 2880;
	localparam int INT_DIV  = 800;
	localparam int P_GAIN   = 150;
	localparam int D_GAIN   = 500;

	// Division by 800 is a shift by 5 followed by a reciprocal multiply for 25.
	localparam int MAG_W       = 20;
	localparam int DIV_LO      = 5;
	localparam int RECIP       = 41944;
	localparam int RECIP_SHIFT = 20;
	localparam int PROD_W      = 31;

	typedef enum logic [CMD_W-1:0] {
		CMD_STEP  = 2'd0,
		CMD_CLEAR = 2'd1,
		CMD_BRAKE = 2'd2,
		CMD_STOP  = 2'd3
	} cmd_t;

endpackage
`default_nettype wire

// ===== rtl/dhpd_if.sv =====
// Interfaces for the step input channel and the wheel drive output channel.
`default_nettype none
interface dhpd_step_if;
	import dhpd_pkg::*;
	logic                        valid;
	logic                        ready;
	logic [CMD_W-1:0]            command;
	logic signed [HEADING_W-1:0] heading;
	logic signed [HEADING_W-1:0] target;
	logic signed [BASE_W-1:0]    base_speed;

	modport source (output valid, command, heading, target, base_speed, input ready);
	modport sink (input valid, command, heading, target, base_speed, output ready);
endinterface

interface dhpd_drive_if;
	import dhpd_pkg::*;
	logic              valid;
	logic              ready;
	logic [DUTY_W-1:0] left_duty;
	logic              left_reverse;
	logic [DUTY_W-1:0] right_duty;
	logic              right_reverse;

	modport source (output valid, left_duty, left_reverse, right_duty, right_reverse,
		input ready);
	modport sink (input valid, left_duty, left_reverse, right_duty, right_reverse,
		output ready);
endinterface
`default_nettype wire

// ===== rtl/differential_heading_pid_drive.sv =====
// Heading PID controller for a two-wheel drive with a four-stage valid/ready pipeline.
//
// channel | dir | payload                                              | transaction
// step    | in  | command, heading, target, base_speed                 | valid && ready
// drive   | out | left_duty, left_reverse, right_duty, right_reverse   | valid && ready
//
// One transaction per cycle is accepted while the pipeline is not backed up by a drive stall.
// The integral and previous heading update when an item leaves the input register stage.
// The last drive values live in the output register, which brake and clear commands reuse.
// Reset clears all valid bits, the integral, the previous heading and the last drives.
// Each stage advances when the stage after it is empty or moving, so bubbles fill under stall.
`default_nettype none
module differential_heading_pid_drive #(
	parameter int DRIVE_LIMIT = dhpd_pkg::DRIVE_LIMIT_DEF,
	parameter int SUM_WIDTH   = dhpd_pkg::SUM_WIDTH_DEF
) (
	input  wire           clk,
	input  wire           arst_n,
	dhpd_step_if.sink     step,
	dhpd_drive_if.source  drive
);
	import dhpd_pkg::*;

	localparam int SW1 = SUM_WIDTH + 1;
	localparam int NW  = ((SUM_WIDTH > DD_W) ? SUM_WIDTH : DD_W) + 3;
	localparam int DW  = $clog2(DRIVE_LIMIT + 1) + 1;

	localparam logic signed [SUM_WIDTH-1:0] SUM_MAX = {1'b0, {(SUM_WIDTH-1){1'b1}}};
	localparam logic signed [SUM_WIDTH-1:0] SUM_MIN = ~SUM_MAX;
	localparam logic signed [HEADING_W-1:0] WRAP_POS = HEADING_W'(WRAP_MAG);
	localparam logic signed [HEADING_W-1:0] WRAP_NEG = -WRAP_POS;
	localparam logic signed [PE_W-1:0] P_GAIN_C = PE_W'(P_GAIN);
	localparam logic signed [DD_W-1:0] D_GAIN_C = DD_W'(D_GAIN);
	localparam logic signed [B_W-1:0]  B_GAIN_C = B_W'(INT_DIV);
	localparam logic signed [NW-1:0] TH_POS = NW'((DRIVE_LIMIT + 1) * INT_DIV);
	localparam logic signed [NW-1:0] TH_NEG = -TH_POS;
	localparam logic signed [DW-1:0] LIM_POS = DW'(DRIVE_LIMIT);
	localparam logic signed [DW-1:0] LIM_NEG = -LIM_POS;
	localparam logic [PROD_W-1:0] RECIP_C = PROD_W'(RECIP);

	function automatic logic signed [DW-1:0] scale_drive(input logic signed [NW-1:0] n);
		logic [NW-1:0]     mag_full;
		logic [MAG_W-1:0]  mag;
		logic [PROD_W-1:0] prod;
		logic [DW-1:0]     q;
		mag_full = n[NW-1] ? NW'(-n) : NW'(n);
		mag      = mag_full[MAG_W-1:0];
		prod     = PROD_W'(mag[MAG_W-1:DIV_LO]) * RECIP_C;
		q        = {1'b0, prod[RECIP_SHIFT +: DW-1]};
		if (n >= TH_POS) begin
			scale_drive = LIM_POS;
		end else if (n <= TH_NEG) begin
			scale_drive = LIM_NEG;
		end else if (n[NW-1]) begin
			scale_drive = -$signed(q);
		end else begin
			scale_drive = $signed(q);
		end
	endfunction

	function automatic logic [DUTY_W-1:0] duty_of(input logic signed [DW-1:0] d);
		logic [DW-1:0]        a;
		logic [DW+DUTY_W-1:0] ext;
		a   = d[DW-1] ? DW'(-d) : DW'(d);
		ext = {{DUTY_W{1'b0}}, a};
		duty_of = ext[DUTY_W-1:0];
	endfunction

	logic rdy_s1, rdy_s2, rdy_s3, rdy_s4;
	logic mv12, mv23, mv34;

	logic                        valid_s1;
	cmd_t                        cmd_s1;
	logic signed [HEADING_W-1:0] heading_s1;
	logic signed [HEADING_W-1:0] target_s1;
	logic signed [BASE_W-1:0]    base_s1;

	logic                        valid_s2;
	cmd_t                        cmd_s2;
	logic signed [SUM_WIDTH-1:0] es_s2;
	logic signed [PE_W-1:0]      pe_s2;
	logic signed [DD_W-1:0]      dd_s2;
	logic signed [B_W-1:0]       b_s2;

	logic                 valid_s3;
	cmd_t                 cmd_s3;
	logic signed [NW-1:0] nr_s3;
	logic signed [NW-1:0] nl_s3;

	logic                 valid_s4;
	logic signed [DW-1:0] left_drive_q;
	logic signed [DW-1:0] right_drive_q;

	logic signed [SUM_WIDTH-1:0] es_q;
	logic signed [HEADING_W-1:0] prev_q;

	logic                        wrap;
	logic signed [E_W-1:0]       e_raw, e_abs, e;
	logic signed [SW1-1:0]       es_sum;
	logic signed [SUM_WIDTH-1:0] es_new;
	logic signed [DH_W-1:0]      dh;
	logic signed [NW-1:0]        es_x, pe_x, dd_x, b_x;

	assign rdy_s4 = !valid_s4 || drive.ready;
	assign rdy_s3 = !valid_s3 || rdy_s4;
	assign rdy_s2 = !valid_s2 || rdy_s3;
	assign rdy_s1 = !valid_s1 || rdy_s2;
	assign mv12   = valid_s1 && rdy_s2;
	assign mv23   = valid_s2 && rdy_s3;
	assign mv34   = valid_s3 && rdy_s4;
	assign step.ready = rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (rdy_s1) begin
				valid_s1 <= step.valid;
			end
			if (rdy_s2) begin
				valid_s2 <= valid_s1;
			end
			if (rdy_s3) begin
				valid_s3 <= valid_s2;
			end
			if (rdy_s4) begin
				valid_s4 <= valid_s3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (step.valid && rdy_s1) begin
			cmd_s1     <= cmd_t'(step.command);
			heading_s1 <= step.heading;
			target_s1  <= step.target;
			base_s1    <= step.base_speed;
		end
	end

	always_comb begin
		wrap   = (target_s1 == WRAP_POS) || (target_s1 == WRAP_NEG);
		e_raw  = E_W'(target_s1) - E_W'(heading_s1);
		e_abs  = e_raw[E_W-1] ? -e_raw : e_raw;
		if (wrap) begin
			e = heading_s1[HEADING_W-1] ? -e_abs : e_abs;
		end else begin
			e = e_raw;
		end
		es_sum = SW1'(es_q) + SW1'(e);
		if (es_sum[SW1-1] != es_sum[SW1-2]) begin
			es_new = es_sum[SW1-1] ? SUM_MIN : SUM_MAX;
		end else begin
			es_new = es_sum[SUM_WIDTH-1:0];
		end
		dh = DH_W'(heading_s1) - DH_W'(prev_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			es_q   <= '0;
			prev_q <= '0;
		end else if (mv12) begin
			unique case (cmd_s1)
				CMD_STEP: begin
					es_q   <= es_new;
					prev_q <= heading_s1;
				end
				CMD_CLEAR: begin
					es_q   <= '0;
					prev_q <= '0;
				end
				CMD_BRAKE, CMD_STOP: begin
					es_q   <= es_q;
					prev_q <= prev_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (mv12) begin
			cmd_s2 <= cmd_s1;
			es_s2  <= es_new;
			pe_s2  <= PE_W'(e) * P_GAIN_C;
			dd_s2  <= DD_W'(dh) * D_GAIN_C;
			b_s2   <= B_W'(base_s1) * B_GAIN_C;
		end
	end

	assign es_x = NW'(es_s2);
	assign pe_x = NW'(pe_s2);
	assign dd_x = NW'(dd_s2);
	assign b_x  = NW'(b_s2);

	always_ff @(posedge clk) begin
		if (mv23) begin
			cmd_s3 <= cmd_s2;
			nr_s3  <= b_x + es_x + pe_x - dd_x;
			nl_s3  <= b_x - es_x - pe_x + dd_x;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_drive_q  <= '0;
			right_drive_q <= '0;
		end else if (mv34) begin
			unique case (cmd_s3)
				CMD_STEP: begin
					left_drive_q  <= scale_drive(nl_s3);
					right_drive_q <= scale_drive(nr_s3);
				end
				CMD_CLEAR: begin
					left_drive_q  <= left_drive_q;
					right_drive_q <= right_drive_q;
				end
				CMD_BRAKE: begin
					left_drive_q  <= -left_drive_q;
					right_drive_q <= -right_drive_q;
				end
				CMD_STOP: begin
					left_drive_q  <= '0;
					right_drive_q <= '0;
				end
			endcase
		end
	end

	assign drive.valid         = valid_s4;
	assign drive.left_duty     = duty_of(left_drive_q);
	assign drive.left_reverse  = left_drive_q[DW-1];
	assign drive.right_duty    = duty_of(right_drive_q);
	assign drive.right_reverse = right_drive_q[DW-1];

`ifndef NO_ASSERTIONS
	a_stop_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(mv34 && cmd_s3 == CMD_STOP) |=> (left_drive_q == '0 && right_drive_q == '0))
		else $error("stop transaction did not zero both drives");

	a_clear_state: assert property (@(posedge clk) disable iff (!arst_n)
		(mv12 && cmd_s1 == CMD_CLEAR) |=> (es_q == '0 && prev_q == '0))
		else $error("clear transaction left integral or previous heading set");

	a_drive_limit: assert property (@(posedge clk) disable iff (!arst_n)
		(left_drive_q <= LIM_POS && left_drive_q >= LIM_NEG &&
		 right_drive_q <= LIM_POS && right_drive_q >= LIM_NEG))
		else $error("drive value beyond the drive limit");

	a_brake_negates: assert property (@(posedge clk) disable iff (!arst_n)
		(mv34 && cmd_s3 == CMD_BRAKE) |=>
		(left_drive_q == -$past(left_drive_q) && right_drive_q == -$past(right_drive_q)))
		else $error("brake transaction did not negate the last drives");
`endif

endmodule
`default_nettype wire

// ===== verif/dhpd_drive_checker.sv =====
// Checker that predicts the wheel drive of each step transaction and compares it with the output.
module dhpd_drive_checker #(
	parameter int DRIVE_LIMIT = dhpd_pkg::DRIVE_LIMIT_DEF,
	parameter int SUM_WIDTH   = dhpd_pkg::SUM_WIDTH_DEF
) (
	input  wire   clk,
	input  wire   arst_n,
	dhpd_step_if  step,
	dhpd_drive_if drive,
	output int    errors,
	output int    pending,
	output int    results_seen,
	output int    saturations,
	output int    wrap_steps
);
	timeunit 1ns;
	timeprecision 1ps;
	import dhpd_pkg::*;

	localparam int     DRIVE_W      = $clog2(DRIVE_LIMIT + 1) + 1;
	localparam longint INTEGRAL_MAX = (longint'(1) <<< (SUM_WIDTH - 1)) - 1;
	localparam longint INTEGRAL_MIN = -INTEGRAL_MAX - 1;

	typedef struct packed {
		logic [DUTY_W-1:0] left_duty;
		logic              left_reverse;
		logic [DUTY_W-1:0] right_duty;
		logic              right_reverse;
	} wheel_duty_t;

	logic signed [SUM_WIDTH-1:0] heading_integral;
	logic signed [HEADING_W-1:0] prior_heading;
	logic signed [DRIVE_W-1:0]   left_drive;
	logic signed [DRIVE_W-1:0]   right_drive;
	wheel_duty_t                 expected_duties[$];
	int                          mismatch_count = 0;
	int                          result_count = 0;
	int                          sat_count = 0;
	int                          wrap_count = 0;

	function automatic longint limit_drive(input longint level);
		if (level > DRIVE_LIMIT)
			return DRIVE_LIMIT;
		if (level < -DRIVE_LIMIT)
			return -DRIVE_LIMIT;
		return level;
	endfunction

	function automatic wheel_duty_t pwm_of(input longint left, input longint right);
		wheel_duty_t duty;
		longint      left_mag;
		longint      right_mag;
		left_mag = left < 0 ? -left : left;
		right_mag = right < 0 ? -right : right;
		duty.left_duty = left_mag[DUTY_W-1:0];
		duty.left_reverse = left < 0;
		duty.right_duty = right_mag[DUTY_W-1:0];
		duty.right_reverse = right < 0;
		return duty;
	endfunction

	// Applies one command to the controller state and returns the wheel duties it sends.
	function automatic wheel_duty_t advance_controller(input cmd_t cmd, input longint hd,
			input longint tg, input longint bs);
		longint err;
		longint total;
		longint corr;
		longint right;
		longint left;
		case (cmd)
			CMD_CLEAR: begin
				heading_integral = '0;
				prior_heading = '0;
			end
			CMD_BRAKE: begin
				left_drive = DRIVE_W'(limit_drive(-longint'(left_drive)));
				right_drive = DRIVE_W'(limit_drive(-longint'(right_drive)));
			end
			CMD_STOP: begin
				left_drive = '0;
				right_drive = '0;
			end
			CMD_STEP: begin
				err = tg - hd;
				if (tg == WRAP_MAG || tg == -WRAP_MAG) begin
					wrap_count++;
					if (err < 0)
						err = -err;
					if (hd < 0)
						err = -err;
				end
				total = longint'(heading_integral) + err;
				if (total > INTEGRAL_MAX) begin
					total = INTEGRAL_MAX;
					sat_count++;
				end else if (total < INTEGRAL_MIN) begin
					total = INTEGRAL_MIN;
					sat_count++;
				end
				heading_integral = total[SUM_WIDTH-1:0];
				corr = total + P_GAIN * err - D_GAIN * (hd - longint'(prior_heading));
				prior_heading = hd[HEADING_W-1:0];
				right = (bs * INT_DIV + corr) / INT_DIV;
				left = (bs * INT_DIV - corr) / INT_DIV;
				right_drive = DRIVE_W'(limit_drive(right));
				left_drive = DRIVE_W'(limit_drive(left));
			end
		endcase
		return pwm_of(longint'(left_drive), longint'(right_drive));
	endfunction

	always @(posedge clk or negedge arst_n) begin
		wheel_duty_t seen;
		wheel_duty_t want;
		if (!arst_n) begin
			heading_integral = '0;
			prior_heading = '0;
			left_drive = '0;
			right_drive = '0;
			expected_duties.delete();
		end else begin
			if (step.valid && step.ready)
				expected_duties.push_back(advance_controller(cmd_t'(step.command),
					longint'(step.heading), longint'(step.target), longint'(step.base_speed)));
			if (drive.valid && drive.ready) begin
				result_count++;
				seen = {drive.left_duty, drive.left_reverse, drive.right_duty, drive.right_reverse};
				if (expected_duties.size() == 0) begin
					mismatch_count++;
					$display("%0t: unexpected drive transaction: left %0d/%0b right %0d/%0b",
						$time, seen.left_duty, seen.left_reverse,
						seen.right_duty, seen.right_reverse);
				end else begin
					want = expected_duties.pop_front();
					if (seen.left_duty !== want.left_duty ||
							seen.left_reverse !== want.left_reverse ||
							seen.right_duty !== want.right_duty ||
							seen.right_reverse !== want.right_reverse) begin
						mismatch_count++;
						$display({"%0t: drive mismatch: expected left %0d/%0b right %0d/%0b,",
							" got left %0d/%0b right %0d/%0b"}, $time,
							want.left_duty, want.left_reverse,
							want.right_duty, want.right_reverse,
							seen.left_duty, seen.left_reverse,
							seen.right_duty, seen.right_reverse);
					end
				end
			end
		end
		errors <= mismatch_count;
		pending <= expected_duties.size();
		results_seen <= result_count;
		saturations <= sat_count;
		wrap_steps <= wrap_count;
	end

endmodule

// ===== verif/tb_differential_heading_pid_drive.sv =====
// Testbench top for the differential heading drive: clock, reset, stimulus and verdict.
module tb_differential_heading_pid_drive;
	timeunit 1ns;
	timeprecision 1ps;
	import dhpd_pkg::*;

	localparam int IDLE_PERCENT = 35;
	localparam int HOLD_CYCLES  = 120;
	localparam int STALL_LIMIT  = 4000;
	localparam int WINDUP_STEPS = 100;
	localparam int RANDOM_ITEMS = 620;

	logic clk;
	logic arst_n;
	int   items_sent = 0;
	int   errors;
	int   pending;
	int   results_seen;
	int   saturations;
	int   wrap_steps;
	int   stall_cycles = 0;
	int   cmd_counts[4] = '{0, 0, 0, 0};
	bit   sender_steady = 1'b0;
	bit   sink_steady = 1'b0;
	bit   sink_hold = 1'b0;

	dhpd_step_if  step();
	dhpd_drive_if drive();

	differential_heading_pid_drive u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.drive  (drive)
	);

	dhpd_drive_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.step         (step),
		.drive        (drive),
		.errors       (errors),
		.pending      (pending),
		.results_seen (results_seen),
		.saturations  (saturations),
		.wrap_steps   (wrap_steps)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	function automatic int clip_angle(input int angle);
		if (angle > WRAP_MAG)
			return WRAP_MAG;
		if (angle < -WRAP_MAG)
			return -WRAP_MAG;
		return angle;
	endfunction

	task automatic send_step(input cmd_t cmd, input int hd, input int tg, input int bs);
		while (!sender_steady && $urandom_range(99) < IDLE_PERCENT) begin
			step.valid <= 1'b0;
			@(posedge clk);
		end
		step.valid <= 1'b1;
		step.command <= cmd;
		step.heading <= hd[HEADING_W-1:0];
		step.target <= tg[HEADING_W-1:0];
		step.base_speed <= bs[BASE_W-1:0];
		@(posedge clk);
		while (!step.ready)
			@(posedge clk);
		items_sent++;
		cmd_counts[cmd]++;
	endtask

	// The output side stalls at random, and once holds off long enough to back up the pipeline.
	initial begin
		drive.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (sink_hold) begin
				drive.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				sink_hold = 1'b0;
			end else begin
				drive.ready <= sink_steady || ($urandom_range(99) >= IDLE_PERCENT);
			end
		end
	end

	always @(posedge clk) begin
		if ((step.valid && step.ready) || (drive.valid && drive.ready)) begin
			stall_cycles <= 0;
		end else if (stall_cycles == STALL_LIMIT) begin
			$display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
			$display("status: fail");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	initial begin
		int walk;
		int pick;
		int hd;
		int tg;
		int bs;
		cmd_t cmd;
		step.valid <= 1'b0;
		step.command <= CMD_STEP;
		step.heading <= '0;
		step.target <= '0;
		step.base_speed <= '0;
		arst_n <= 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_step(CMD_STEP, 0, 0, 0);
		send_step(CMD_STEP, 0, 0, 255);
		send_step(CMD_STEP, 0, 0, -255);
		send_step(CMD_STEP, -2880, 2879, 0);
		send_step(CMD_STEP, 2880, -2879, 0);
		send_step(CMD_STEP, 2880, -WRAP_MAG, 100);
		send_step(CMD_STEP, -2880, WRAP_MAG, -100);
		send_step(CMD_STEP, 0, WRAP_MAG, 0);
		send_step(CMD_STEP, -1, -WRAP_MAG, 0);
		send_step(CMD_BRAKE, 0, 0, 0);
		send_step(CMD_BRAKE, 0, 0, 0);
		send_step(CMD_CLEAR, 2880, -2880, 255);
		send_step(CMD_STEP, 0, 1, 0);
		send_step(CMD_STEP, 1, 0, 0);
		send_step(CMD_STEP, -1, 0, 0);
		send_step(CMD_STOP, -2880, 2880, -255);
		send_step(CMD_BRAKE, 0, 0, 0);
		send_step(CMD_STEP, 100, 100, 255);
		send_step(CMD_STEP, -100, -100, -255);
		send_step(CMD_CLEAR, 0, 0, 0);
		send_step(CMD_STEP, -2880, -WRAP_MAG, -255);

		// Wind the integral up in both directions, the first time with no idling at all.
		sender_steady = 1'b1;
		sink_steady = 1'b1;
		send_step(CMD_CLEAR, 0, 0, 0);
		for (int i = 0; i < WINDUP_STEPS; i++)
			send_step(CMD_STEP, -2880 + int'($urandom_range(20)), 2879 - int'($urandom_range(20)),
				int'($urandom_range(510)) - 255);
		sender_steady = 1'b0;
		sink_steady = 1'b0;
		send_step(CMD_CLEAR, 0, 0, 0);
		for (int i = 0; i < WINDUP_STEPS; i++)
			send_step(CMD_STEP, 2880 - int'($urandom_range(20)), -2879 + int'($urandom_range(20)),
				int'($urandom_range(510)) - 255);
		send_step(CMD_CLEAR, 0, 0, 0);

		walk = 0;
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			sender_steady = i >= 300 && i < 360;
			sink_steady = i >= 500 && i < 600;
			if (i == 310)
				sink_hold = 1'b1;
			pick = $urandom_range(99);
			if (pick < 80)
				cmd = CMD_STEP;
			else if (pick < 87)
				cmd = CMD_CLEAR;
			else if (pick < 94)
				cmd = CMD_BRAKE;
			else
				cmd = CMD_STOP;
			if ($urandom_range(99) < 60) begin
				walk = clip_angle(walk + int'($urandom_range(80)) - 40);
				hd = walk;
				tg = clip_angle(walk + int'($urandom_range(128)) - 64);
				bs = int'($urandom_range(400)) - 200;
			end else begin
				hd = int'($urandom_range(5760)) - 2880;
				tg = int'($urandom_range(5760)) - 2880;
				bs = int'($urandom_range(510)) - 255;
				if ($urandom_range(99) < 20)
					tg = $urandom_range(1) ? WRAP_MAG : -WRAP_MAG;
			end
			send_step(cmd, hd, tg, bs);
		end
		step.valid <= 1'b0;

		while (results_seen < items_sent)
			@(posedge clk);
		repeat (8) @(posedge clk);

		$display("Sent %0d step transactions (%0d control, %0d clear, %0d brake, %0d stop), %0d results.",
			items_sent, cmd_counts[CMD_STEP], cmd_counts[CMD_CLEAR], cmd_counts[CMD_BRAKE],
			cmd_counts[CMD_STOP], results_seen);
		$display("Integral clipped on %0d steps, %0d steps had a wrap target, one long output hold-off.",
			saturations, wrap_steps);
		if (pending != 0)
			$display("%0t: %0d expected drive results never arrived", $time, pending);
		if (errors == 0 && pending == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
